[sv/sbdp_pkg.sv]
`timescale 1ns / 1ps

package sbdp_pkg;

    // element and coefficient formats
    localparam int DATA_W = 16;
    localparam int ACC_W  = 48;
    localparam int COEF_W = 16;
    localparam int OLD_W  = 32;
    localparam int OUT_W  = 32;

    // one complex product term, a*b plus or minus a*b
    localparam int PROD_W = 2 * DATA_W + 1;
    localparam int SUMX_W = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;

    // fraction bits of alpha*sum and of beta*old, and the common alignment
    localparam int FRAC_A     = 2 * DATA_W + 10;
    localparam int FRAC_B     = 36;
    localparam int FRAC_ALIGN = (FRAC_A > FRAC_B) ? FRAC_A : FRAC_B;
    localparam int SH_A       = FRAC_ALIGN - FRAC_A;
    localparam int SH_B       = FRAC_ALIGN - FRAC_B;
    localparam int TA_W       = ACC_W + COEF_W + 1;
    localparam int TB_W       = OLD_W + COEF_W + 1;
    localparam int S_W        = (((TA_W + SH_A) > (TB_W + SH_B)) ? (TA_W + SH_A)
                                                                : (TB_W + SH_B)) + 1;
    localparam int RND_POS    = FRAC_ALIGN - 25;
    localparam int SAR        = FRAC_ALIGN - 24;
    localparam int R_W        = S_W - SAR;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_REAL   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IMAG   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_REAL    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_IMAG    = CFG_IDX_W'(4);

    localparam logic signed [COEF_W-1:0] ALPHA_REAL_RESET = COEF_W'(4096);

    typedef struct packed {
        logic signed [DATA_W-1:0] a_real;
        logic signed [DATA_W-1:0] a_imag;
        logic signed [DATA_W-1:0] b_real;
        logic signed [DATA_W-1:0] b_imag;
        logic signed [OLD_W-1:0]  old_real;
        logic signed [OLD_W-1:0]  old_imag;
        logic                     row_end;
    } item_t;

    typedef struct packed {
        logic                     complex_mode;
        logic signed [COEF_W-1:0] alpha_real;
        logic signed [COEF_W-1:0] alpha_imag;
        logic signed [COEF_W-1:0] beta_real;
        logic signed [COEF_W-1:0] beta_imag;
    } cfg_t;

endpackage

[sv/sbdp_front.sv]
`timescale 1ns / 1ps

module sbdp_front
    import sbdp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_pop,
    output item_t q_item
);

    item_t             mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_AW:0]     count_reg;
    logic [Q_AW:0]     count_next;
    logic              push;
    logic              pop;

    assign in_stall = (count_reg == (Q_AW + 1)'(Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    assign push = in_valid && !in_stall;
    assign pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[sv/sbdp_back.sv]
`timescale 1ns / 1ps

module sbdp_back
    import sbdp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  item_t                   q_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] new_real,
    output logic signed [OUT_W-1:0] new_imag,
    output logic                    saturated
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_FIN1 = 2'd1;
    localparam logic [1:0] ST_FIN2 = 2'd2;
    localparam logic [1:0] ST_FIN3 = 2'd3;

    localparam int MUL_W = 2 * DATA_W;
    localparam int TAP_W = ACC_W + COEF_W;
    localparam int TBP_W = OLD_W + COEF_W;

    localparam logic signed [SUMX_W-1:0] ACC_MAX = SUMX_W'({1'b0, {(ACC_W-1){1'b1}}});
    localparam logic signed [SUMX_W-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [OUT_W-1:0]  OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]  OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic                    clip;
    } acc_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    clip;
    } fin_t;

    function automatic acc_t acc_add(input logic signed [ACC_W-1:0] acc,
                                     input logic signed [PROD_W-1:0] p);
        logic signed [SUMX_W-1:0] x;
        acc_t                     r;
        x = SUMX_W'(acc) + SUMX_W'(p);
        r.clip = 1'b1;
        if (x > ACC_MAX)
        begin
            r.sum = ACC_W'(ACC_MAX);
        end
        else if (x < ACC_MIN)
        begin
            r.sum = ACC_W'(ACC_MIN);
        end
        else
        begin
            r.sum  = ACC_W'(x);
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // align both terms, round half up, drop to Q8.24 and clip
    function automatic fin_t finish(input logic signed [TA_W-1:0] t,
                                    input logic signed [TB_W-1:0] u);
        logic signed [S_W-1:0] s;
        logic signed [R_W-1:0] r;
        logic [R_W-OUT_W:0]    hi;
        logic                  fits;
        fin_t                  f;
        s    = (S_W'(t) <<< SH_A) + (S_W'(u) <<< SH_B) + (S_W'(1) <<< RND_POS);
        r    = s[S_W-1:SAR];
        hi   = r[R_W-1:OUT_W-1];
        fits = (&hi) || !(|hi);
        f.clip  = !fits;
        f.value = fits ? r[OUT_W-1:0] : (r[R_W-1] ? OUT_MIN : OUT_MAX);
        return f;
    endfunction

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;

    logic                            p_valid_reg;
    logic                            p_valid_next;
    logic                            p_last_reg;
    logic signed [PROD_W-1:0]        p_real_reg;
    logic signed [PROD_W-1:0]        p_imag_reg;
    logic signed [OLD_W-1:0]         p_old_real_reg;
    logic signed [OLD_W-1:0]         p_old_imag_reg;

    logic signed [ACC_W-1:0]         sum_real_reg;
    logic signed [ACC_W-1:0]         sum_real_next;
    logic signed [ACC_W-1:0]         sum_imag_reg;
    logic signed [ACC_W-1:0]         sum_imag_next;
    logic                            clip_reg;
    logic                            clip_next;
    logic                            fin_clip_reg;
    logic                            fin_clip_next;

    logic signed [ACC_W+COEF_W-1:0]  ta_rr_reg;
    logic signed [ACC_W+COEF_W-1:0]  ta_ii_reg;
    logic signed [ACC_W+COEF_W-1:0]  ta_ir_reg;
    logic signed [ACC_W+COEF_W-1:0]  ta_ri_reg;
    logic signed [OLD_W+COEF_W-1:0]  tb_rr_reg;
    logic signed [OLD_W+COEF_W-1:0]  tb_ii_reg;
    logic signed [OLD_W+COEF_W-1:0]  tb_ri_reg;
    logic signed [OLD_W+COEF_W-1:0]  tb_ir_reg;

    logic signed [TA_W-1:0]          t_real_reg;
    logic signed [TA_W-1:0]          t_imag_reg;
    logic signed [TB_W-1:0]          u_real_reg;
    logic signed [TB_W-1:0]          u_imag_reg;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic signed [OUT_W-1:0]         new_real_reg;
    logic signed [OUT_W-1:0]         new_imag_reg;
    logic                            saturated_reg;

    logic signed [2*DATA_W-1:0]      m_rr;
    logic signed [2*DATA_W-1:0]      m_ii;
    logic signed [2*DATA_W-1:0]      m_ri;
    logic signed [2*DATA_W-1:0]      m_ir;
    logic signed [PROD_W-1:0]        prod_real;
    logic signed [PROD_W-1:0]        prod_imag;
    acc_t                            acc_r;
    acc_t                            acc_i;
    fin_t                            fin_r;
    fin_t                            fin_i;
    logic                            accumulate;
    logic                            out_load;

    assign q_pop = (state_reg == ST_RUN) && q_valid && !(p_valid_reg && p_last_reg);

    // product stage
    assign m_rr = MUL_W'($signed(q_item.a_real)) * MUL_W'($signed(q_item.b_real));
    assign m_ii = MUL_W'($signed(q_item.a_imag)) * MUL_W'($signed(q_item.b_imag));
    assign m_ri = MUL_W'($signed(q_item.a_real)) * MUL_W'($signed(q_item.b_imag));
    assign m_ir = MUL_W'($signed(q_item.a_imag)) * MUL_W'($signed(q_item.b_real));

    assign prod_real = cfg.complex_mode ? (PROD_W'(m_rr) - PROD_W'(m_ii)) : PROD_W'(m_rr);
    assign prod_imag = PROD_W'(m_ri) + PROD_W'(m_ir);

    // accumulate stage
    assign accumulate = (state_reg == ST_RUN) && p_valid_reg;
    assign acc_r      = acc_add(sum_real_reg, p_real_reg);
    assign acc_i      = acc_add(sum_imag_reg, p_imag_reg);

    assign fin_r    = finish(t_real_reg, u_real_reg);
    assign fin_i    = finish(t_imag_reg, u_imag_reg);
    assign out_load = (state_reg == ST_FIN3) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        p_valid_next   = 1'b0;
        sum_real_next  = sum_real_reg;
        sum_imag_next  = sum_imag_reg;
        clip_next      = clip_reg;
        fin_clip_next  = fin_clip_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_RUN:
            begin
                p_valid_next = q_pop;
                if (accumulate)
                begin
                    sum_real_next = acc_r.sum;
                    clip_next     = clip_reg || acc_r.clip;
                    if (cfg.complex_mode)
                    begin
                        sum_imag_next = acc_i.sum;
                        clip_next     = clip_reg || acc_r.clip || acc_i.clip;
                    end
                    if (p_last_reg)
                    begin
                        state_next = ST_FIN1;
                    end
                end
            end
            ST_FIN1:
            begin
                // products of the sum are taken this cycle; the row starts afresh
                sum_real_next = '0;
                sum_imag_next = '0;
                clip_next     = 1'b0;
                fin_clip_next = clip_reg;
                state_next    = ST_FIN2;
            end
            ST_FIN2:
            begin
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            p_valid_reg   <= 1'b0;
            sum_real_reg  <= '0;
            sum_imag_reg  <= '0;
            clip_reg      <= 1'b0;
            fin_clip_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_valid_reg   <= p_valid_next;
            sum_real_reg  <= sum_real_next;
            sum_imag_reg  <= sum_imag_next;
            clip_reg      <= clip_next;
            fin_clip_reg  <= fin_clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_last_reg     <= q_item.row_end;
            p_real_reg     <= prod_real;
            p_imag_reg     <= prod_imag;
            p_old_real_reg <= q_item.old_real;
            p_old_imag_reg <= q_item.old_imag;
        end
        if (state_reg == ST_FIN1)
        begin
            ta_rr_reg <= TAP_W'(sum_real_reg) * TAP_W'($signed(cfg.alpha_real));
            ta_ii_reg <= TAP_W'(sum_imag_reg) * TAP_W'($signed(cfg.alpha_imag));
            ta_ir_reg <= TAP_W'(sum_imag_reg) * TAP_W'($signed(cfg.alpha_real));
            ta_ri_reg <= TAP_W'(sum_real_reg) * TAP_W'($signed(cfg.alpha_imag));
            tb_rr_reg <= TBP_W'($signed(cfg.beta_real)) * TBP_W'(p_old_real_reg);
            tb_ii_reg <= TBP_W'($signed(cfg.beta_imag)) * TBP_W'(p_old_imag_reg);
            tb_ri_reg <= TBP_W'($signed(cfg.beta_real)) * TBP_W'(p_old_imag_reg);
            tb_ir_reg <= TBP_W'($signed(cfg.beta_imag)) * TBP_W'(p_old_real_reg);
        end
        if (state_reg == ST_FIN2)
        begin
            t_real_reg <= cfg.complex_mode ? (TA_W'(ta_rr_reg) - TA_W'(ta_ii_reg))
                                           : TA_W'(ta_rr_reg);
            t_imag_reg <= TA_W'(ta_ir_reg) + TA_W'(ta_ri_reg);
            u_real_reg <= cfg.complex_mode ? (TB_W'(tb_rr_reg) - TB_W'(tb_ii_reg))
                                           : TB_W'(tb_rr_reg);
            u_imag_reg <= TB_W'(tb_ri_reg) + TB_W'(tb_ir_reg);
        end
        if (out_load)
        begin
            new_real_reg  <= fin_r.value;
            new_imag_reg  <= cfg.complex_mode ? fin_i.value : '0;
            saturated_reg <= fin_clip_reg || fin_r.clip || (cfg.complex_mode && fin_i.clip);
        end
    end

    assign out_valid = out_valid_reg;
    assign new_real  = new_real_reg;
    assign new_imag  = new_imag_reg;
    assign saturated = saturated_reg;

endmodule

[sv/scaled_batched_dot_product.sv]
`timescale 1ns / 1ps

// Scaled batched dot product: new = beta*old + alpha*sum(a*b) per row.
// Input channel (in_valid / in_stall): one element pair a, b per transfer, real or
// complex as set by complex_mode; row_end marks the last pair, and old_real /
// old_imag are taken with that pair only. Output channel (out_valid / out_stall):
// one result per row, Q8.24, saturated, with a flag for any clipping in the row.
// Throughput: one pair per cycle inside a row while the queue has room; a row end
// then passes through the back end: the last pair's accumulate, a multiply and a
// sum stage for alpha/beta, and a round-and-clip stage.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user must
// do so only while idle; the block does not enforce it. Unknown indexes are ignored.
// A four-entry queue sits between the input side and the multiply-accumulate
// engine, so pairs keep being taken while a result waits under out_stall; once the
// queue fills, in_stall rises. The engine holds its finished result until the
// output register is free and meanwhile accepts nothing from the queue.
// Reset (rst_n low, asynchronous) empties the queue, clears the accumulators and
// clip flag, and sets alpha to 1.0, beta to 0, real mode.

module scaled_batched_dot_product
    import sbdp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_W-1:0]     a_real,
    input  logic signed [DATA_W-1:0]     a_imag,
    input  logic signed [DATA_W-1:0]     b_real,
    input  logic signed [DATA_W-1:0]     b_imag,
    input  logic signed [OLD_W-1:0]      old_real,
    input  logic signed [OLD_W-1:0]      old_imag,
    input  logic                         row_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [OUT_W-1:0]      new_real,
    output logic signed [OUT_W-1:0]      new_imag,
    output logic                         saturated
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COMPLEX_MODE: cfg_next.complex_mode = cfg_data[0];
                REG_ALPHA_REAL:   cfg_next.alpha_real   = COEF_W'(cfg_data);
                REG_ALPHA_IMAG:   cfg_next.alpha_imag   = COEF_W'(cfg_data);
                REG_BETA_REAL:    cfg_next.beta_real    = COEF_W'(cfg_data);
                REG_BETA_IMAG:    cfg_next.beta_imag    = COEF_W'(cfg_data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.complex_mode <= 1'b0;
            cfg_reg.alpha_real   <= ALPHA_REAL_RESET;
            cfg_reg.alpha_imag   <= '0;
            cfg_reg.beta_real    <= '0;
            cfg_reg.beta_imag    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        in_item.a_real   = a_real;
        in_item.a_imag   = a_imag;
        in_item.b_real   = b_real;
        in_item.b_imag   = b_imag;
        in_item.old_real = old_real;
        in_item.old_imag = old_imag;
        in_item.row_end  = row_end;
    end

    sbdp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    sbdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_real  (new_real),
        .new_imag  (new_imag),
        .saturated (saturated)
    );

endmodule

[sv/sbdp_checker.sv]
`timescale 1ns / 1ps

module sbdp_checker
    import sbdp_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_write,
    input logic [CFG_IDX_W-1:0]     cfg_index,
    input logic [CFG_DATA_W-1:0]    cfg_data,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic signed [DATA_W-1:0] a_real,
    input logic signed [DATA_W-1:0] a_imag,
    input logic signed [DATA_W-1:0] b_real,
    input logic signed [DATA_W-1:0] b_imag,
    input logic signed [OLD_W-1:0]  old_real,
    input logic signed [OLD_W-1:0]  old_imag,
    input logic                     row_end,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [OUT_W-1:0]  new_real,
    input logic signed [OUT_W-1:0]  new_imag,
    input logic                     saturated
);

    logic mode_reg;

    // shadow of complex_mode, seen from the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_write && (cfg_index == REG_COMPLEX_MODE))
        begin
            mode_reg <= cfg_data[0];
        end
    end

    // out_valid is reset low, so no result is presented right after reset
    a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result presented straight out of reset");

    a_real_mode_imag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mode_reg |-> (new_imag == '0))
        else $error("imaginary part nonzero in real mode");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(new_real) && $stable(new_imag)
                                   && $stable(saturated))
        else $error("stalled result changed");

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid
            && $stable({a_real, a_imag, b_real, b_imag, old_real, old_imag, row_end}))
        else $error("stalled input transfer changed");

endmodule

bind scaled_batched_dot_product sbdp_checker u_sbdp_checker (.*);
